@@ design/ws2812_pixel_serializer_macros.svh @@
// ----------------------------------------------------------------------------
// ws2812 pixel serializer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef WS2812_PIXEL_SERIALIZER_MACROS_SVH
`define WS2812_PIXEL_SERIALIZER_MACROS_SVH

// same-cycle implication, off during reset
`define WPS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wps assertion failed");

// next-cycle implication, also checked across reset
`define WPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("wps assertion failed");

`endif

@@ design/wps_pkg.sv @@
// ----------------------------------------------------------------------------
// wps_pkg
// shared types and constants of the ws2812 pixel serializer
// ----------------------------------------------------------------------------
`default_nettype none

package wps_pkg;

    localparam int DEF_MAX_PIXELS = 256;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int COLOR_W    = 24;
    localparam int INDEX_W    = 8;
    localparam int TICK_W     = 8;
    localparam int BITPOS_W   = 5;

    localparam logic [BITPOS_W-1:0] LAST_BIT = 5'd23;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_PIXEL_COUNT = 9'd0;
    localparam logic [TICK_W-1:0]     RST_ONE_HIGH    = 8'd7;
    localparam logic [TICK_W-1:0]     RST_ZERO_HIGH   = 8'd2;
    localparam logic [TICK_W-1:0]     RST_ONE_LOW     = 8'd4;
    localparam logic [TICK_W-1:0]     RST_ZERO_LOW    = 8'd4;

    typedef enum logic [IN_USER_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_SHOW  = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef struct packed {
        logic frame_done;
        logic busy_res;
        logic line_level;
    } t_result;

endpackage

`default_nettype wire

@@ design/wps_ram.sv @@
// ----------------------------------------------------------------------------
// wps_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module wps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/wps_skid.sv @@
// ----------------------------------------------------------------------------
// wps_skid
// output register with a skid stage, ready is registered
// ----------------------------------------------------------------------------
`default_nettype none

module wps_skid #(
    parameter int WIDTH = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic      [WIDTH-1:0] o_data
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid_data;
    logic             w_accept;
    logic             w_out_free;

    assign w_accept   = i_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
                r_out_data  <= i_data;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

@@ design/ws2812_pixel_serializer.sv @@
// ----------------------------------------------------------------------------
// ws2812_pixel_serializer
// single-wire rgb led serializer driven by write, show and tick items
// ----------------------------------------------------------------------------
// Input channel: tuser carries the item kind (write pixel, show frame, tick),
// tdata carries the pixel index and 24-bit color. Every accepted item gives
// exactly one result item: tdata bit 0 is the line level, bit 1 the busy flag,
// tlast marks the tick that ends the last low phase of a frame.
// Each item is handled in the cycle it is accepted; its result is registered
// in the output stage. One item per cycle is sustained while the receiver
// does not stall: the pixel store is read ahead at the next pixel address, so
// every tick finds the current pixel color already registered at the ram output.
// After reset the pixel store is zeroed by a pass over all MAX_PIXELS addresses
// during which the input is not ready; configuration writes are taken at any time.
// When the receiver stalls, one further result is held in a skid stage and
// input ready drops until the output drains.
// Configuration writes go through i_cfg_we, i_cfg_idx and i_cfg_data and take
// effect at the next edge; they belong to idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module ws2812_pixel_serializer #(
    parameter int MAX_PIXELS = wps_pkg::DEF_MAX_PIXELS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // [7:0] pixel_index, [31:8] color
    input  wire logic [wps_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] kind
    input  wire logic [wps_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [0] line_level, [1] busy_res, [7:2] zero
    output logic      [wps_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // frame_done
    output logic                                  o_m_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    input  wire logic                             i_cfg_we,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [wps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import wps_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;

    // configuration
    logic [CFG_DATA_W-1:0] r_pixel_count;
    logic [TICK_W-1:0]     r_one_high;
    logic [TICK_W-1:0]     r_zero_high;
    logic [TICK_W-1:0]     r_one_low;
    logic [TICK_W-1:0]     r_zero_low;

    // frame state
    logic                r_sending,  n_sending;
    logic                r_high,     n_high;
    logic [AW-1:0]       r_pointer,  n_pointer;
    logic [BITPOS_W-1:0] r_bitpos,   n_bitpos;
    logic [TICK_W-1:0]   r_phase,    n_phase;

    // store clearing pass
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    logic               w_skid_ready;
    logic               w_accept;
    t_kind              w_kind;
    logic [INDEX_W-1:0] w_index;
    logic [COLOR_W-1:0] w_color;
    logic [CW-1:0]      w_active;
    logic [CW-1:0]      w_count_ext;
    logic [CW-1:0]      w_index_ext;
    logic [CW-1:0]      w_next_ptr_ext;
    logic [COLOR_W-1:0] w_pixel;
    logic               w_bit;
    logic [TICK_W-1:0]  w_len_raw;
    logic [TICK_W-1:0]  w_len;
    logic [TICK_W-1:0]  w_phase_inc;
    logic               w_done;
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [COLOR_W-1:0] w_ram_wdata;
    t_result            w_result;
    t_result            w_out;

    assign w_kind  = t_kind'(i_s_axis_tuser);
    assign w_index = i_s_axis_tdata[INDEX_W-1:0];
    assign w_color = i_s_axis_tdata[INDEX_W +: COLOR_W];

    assign o_s_axis_tready = w_skid_ready && !r_clr_active;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_count_ext    = CW'(r_pixel_count);
    assign w_active       = (w_count_ext > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : w_count_ext;
    assign w_index_ext    = CW'(w_index);
    assign w_next_ptr_ext = CW'(r_pointer) + CW'(1);

    // low color byte first, msb first within each byte
    assign w_bit       = w_pixel[{r_bitpos[4:3], ~r_bitpos[2:0]}];
    assign w_len_raw   = r_high ? (w_bit ? r_one_high : r_zero_high)
                                : (w_bit ? r_one_low  : r_zero_low);
    assign w_len       = (w_len_raw == '0) ? TICK_W'(1) : w_len_raw;
    assign w_phase_inc = r_phase + TICK_W'(1);

    always_comb begin
        n_sending   = r_sending;
        n_high      = r_high;
        n_pointer   = r_pointer;
        n_bitpos    = r_bitpos;
        n_phase     = r_phase;
        w_done      = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = w_index_ext[AW-1:0];
        w_ram_wdata = w_color;
        if (r_clr_active) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_addr;
            w_ram_wdata = '0;
        end else if (w_accept) begin
            unique case (w_kind)
                KIND_WRITE: begin
                    w_ram_we = !r_sending && (w_index_ext < w_active);
                end
                KIND_SHOW: begin
                    if (!r_sending && (w_active != '0)) begin
                        n_sending = 1'b1;
                        n_high    = 1'b1;
                        n_pointer = '0;
                        n_bitpos  = '0;
                        n_phase   = '0;
                    end
                end
                KIND_TICK: begin
                    if (r_sending) begin
                        if (w_phase_inc >= w_len) begin
                            n_phase = '0;
                            if (r_high) begin
                                n_high = 1'b0;
                            end else if (r_bitpos < LAST_BIT) begin
                                n_bitpos = r_bitpos + BITPOS_W'(1);
                                n_high   = 1'b1;
                            end else if (w_next_ptr_ext < w_active) begin
                                n_pointer = r_pointer + AW'(1);
                                n_bitpos  = '0;
                                n_high    = 1'b1;
                            end else begin
                                n_sending = 1'b0;
                                n_pointer = '0;
                                n_bitpos  = '0;
                                w_done    = 1'b1;
                            end
                        end else begin
                            n_phase = w_phase_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_result.line_level = n_sending && n_high;
    assign w_result.busy_res   = n_sending;
    assign w_result.frame_done = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending    <= 1'b0;
            r_high       <= 1'b0;
            r_pointer    <= '0;
            r_bitpos     <= '0;
            r_phase      <= '0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            r_sending <= n_sending;
            r_high    <= n_high;
            r_pointer <= n_pointer;
            r_bitpos  <= n_bitpos;
            r_phase   <= n_phase;
            if (r_clr_active) begin
                if (r_clr_addr == AW'(MAX_PIXELS - 1)) begin
                    r_clr_active <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= RST_PIXEL_COUNT;
            r_one_high    <= RST_ONE_HIGH;
            r_zero_high   <= RST_ZERO_HIGH;
            r_one_low     <= RST_ONE_LOW;
            r_zero_low    <= RST_ZERO_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PIXEL_COUNT: r_pixel_count <= i_cfg_data;
                REG_ONE_HIGH:    r_one_high    <= i_cfg_data[TICK_W-1:0];
                REG_ZERO_HIGH:   r_zero_high   <= i_cfg_data[TICK_W-1:0];
                REG_ONE_LOW:     r_one_low     <= i_cfg_data[TICK_W-1:0];
                REG_ZERO_LOW:    r_zero_low    <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read address follows the next pointer so the color is ready together with the updated pointer
    wps_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (n_pointer),
        .o_rdata (w_pixel)
    );

    wps_skid #(
        .WIDTH ($bits(t_result))
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .o_ready (w_skid_ready),
        .i_data  (w_result),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - 2)'(0), w_out.busy_res, w_out.line_level};
    assign o_m_axis_tlast = w_out.frame_done;

endmodule

`default_nettype wire

@@ design/wps_checker.sv @@
// ----------------------------------------------------------------------------
// wps_checker
// port-level checks of the ws2812 pixel serializer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ws2812_pixel_serializer_macros.svh"

module wps_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_s_axis_tready,
    input wire logic [wps_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                           o_m_axis_tlast,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready
);

    // frame end item reports the block idle
    `WPS_ASSERT_IMPL(a_done_idle, o_m_axis_tvalid && o_m_axis_tlast, !o_m_axis_tdata[1])

    // line only goes high inside a frame
    `WPS_ASSERT_IMPL(a_line_busy, o_m_axis_tvalid && o_m_axis_tdata[0], o_m_axis_tdata[1])

    // stalled result stays offered
    `WPS_ASSERT_IMPL(a_hold, $past(o_m_axis_tvalid && !i_m_axis_tready) && $past(i_rst_n), o_m_axis_tvalid)

    // reset empties the output and starts the store clearing pass
    `WPS_ASSERT_NEXT(a_reset, !i_rst_n, !o_m_axis_tvalid && !o_s_axis_tready)

endmodule

bind ws2812_pixel_serializer wps_checker u_wps_checker (.*);

`default_nettype wire
